// ===== sv/vr2_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package vr2_pkg;

  localparam int COORD_W   = 32;
  localparam int ANGLE_W   = 16;
  localparam int TRIG_ITER = 16;

  localparam int FRAC      = 30;
  localparam int TRIG_W    = FRAC + 4;
  localparam int ZW        = 36;
  localparam int ANG_SHIFT = 33 - ANGLE_W;
  localparam int PROD_W    = COORD_W + TRIG_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int RND_W     = SUM_W - FRAC;

  localparam int IN_FIELDS_W  = 3 * COORD_W + 2 * ANGLE_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 3 * COORD_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN  = TRIG_W'(34'sh026DD3B6A);
  localparam logic signed [ZW-1:0]     PI_Q30       = ZW'(36'sd3373259426);
  localparam logic signed [ZW-1:0]     HALF_PI_Q30  = ZW'(36'sd1686629713);
  localparam logic signed [ZW-1:0]     NHALF_PI_Q30 = -HALF_PI_Q30;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vec_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] s;
    logic signed [TRIG_W-1:0] c;
  } trig_t;

  typedef struct packed {
    logic                      ovf;
    logic signed [COORD_W-1:0] keep;
    trig_t                     trig;
  } side_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return ZW'(v);
  endfunction

endpackage
`default_nettype wire

// ===== sv/vr2_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vr2_cordic import vr2_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire vec_t                      in_vec,
  input  wire logic signed [ANGLE_W-1:0] in_pitch,
  input  wire logic signed [ANGLE_W-1:0] in_yaw,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output vec_t                           out_vec,
  output trig_t                          out_tp,
  output trig_t                          out_tw
);

  localparam int NS = TRIG_ITER + 1;

  logic                     v_r    [NS];
  logic                     adv    [NS];
  vec_t                     vec_r  [NS];
  logic signed [TRIG_W-1:0] cx_r   [2][NS];
  logic signed [TRIG_W-1:0] cy_r   [2][NS];
  logic signed [ZW-1:0]     cz_r   [2][NS];
  logic                     flip_r [2][NS];
  logic signed [ANGLE_W-1:0] ang   [2];

  assign ang[0] = in_pitch;
  assign ang[1] = in_yaw;
  assign in_ready = adv[0];

  genvar k, l;
  generate
    for (k = 0; k < NS; k++) begin : g_stage
      if (k == NS - 1) begin : g_last
        assign adv[k] = !v_r[k] || out_ready;
      end else begin : g_mid
        assign adv[k] = !v_r[k] || adv[k+1];
      end

      if (k == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            v_r[k] <= 1'b0;
          end else if (adv[k]) begin
            v_r[k] <= in_valid;
          end
        end
        always_ff @(posedge clk) begin
          if (adv[k] && in_valid) begin
            vec_r[k] <= in_vec;
          end
        end
        for (l = 0; l < 2; l++) begin : g_lane
          logic signed [ZW-1:0] zs;
          logic signed [ZW-1:0] z_nxt;
          logic                 flip_nxt;
          assign zs = ZW'(ang[l]) <<< ANG_SHIFT;
          always_comb begin
            z_nxt    = zs;
            flip_nxt = 1'b0;
            if (zs > HALF_PI_Q30) begin
              z_nxt    = zs - PI_Q30;
              flip_nxt = 1'b1;
            end else if (zs < NHALF_PI_Q30) begin
              z_nxt    = zs + PI_Q30;
              flip_nxt = 1'b1;
            end
          end
          always_ff @(posedge clk) begin
            if (adv[k] && in_valid) begin
              cx_r[l][k]   <= CORDIC_GAIN;
              cy_r[l][k]   <= '0;
              cz_r[l][k]   <= z_nxt;
              flip_r[l][k] <= flip_nxt;
            end
          end
        end
      end else begin : g_iter
        localparam logic signed [ZW-1:0] ATAN_K = atan_q30(k - 1);
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            v_r[k] <= 1'b0;
          end else if (adv[k]) begin
            v_r[k] <= v_r[k-1];
          end
        end
        always_ff @(posedge clk) begin
          if (adv[k] && v_r[k-1]) begin
            vec_r[k] <= vec_r[k-1];
          end
        end
        for (l = 0; l < 2; l++) begin : g_lane
          logic signed [TRIG_W-1:0] xs, ys, x_nxt, y_nxt;
          logic signed [ZW-1:0]     z_nxt;
          logic                     pos;
          assign xs  = cx_r[l][k-1] >>> (k - 1);
          assign ys  = cy_r[l][k-1] >>> (k - 1);
          assign pos = !cz_r[l][k-1][ZW-1];
          always_comb begin
            if (pos) begin
              x_nxt = cx_r[l][k-1] - ys;
              y_nxt = cy_r[l][k-1] + xs;
              z_nxt = cz_r[l][k-1] - ATAN_K;
            end else begin
              x_nxt = cx_r[l][k-1] + ys;
              y_nxt = cy_r[l][k-1] - xs;
              z_nxt = cz_r[l][k-1] + ATAN_K;
            end
            if (k == NS - 1 && flip_r[l][k-1]) begin
              x_nxt = -x_nxt;
              y_nxt = -y_nxt;
            end
          end
          always_ff @(posedge clk) begin
            if (adv[k] && v_r[k-1]) begin
              cx_r[l][k]   <= x_nxt;
              cy_r[l][k]   <= y_nxt;
              cz_r[l][k]   <= z_nxt;
              flip_r[l][k] <= flip_r[l][k-1];
            end
          end
        end
      end
    end
  endgenerate

  assign out_valid = v_r[NS-1];
  assign out_vec   = vec_r[NS-1];
  assign out_tp.c  = cx_r[0][NS-1];
  assign out_tp.s  = cy_r[0][NS-1];
  assign out_tw.c  = cx_r[1][NS-1];
  assign out_tw.s  = cy_r[1][NS-1];

endmodule
`default_nettype wire

// ===== sv/vr2_rotate.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vr2_rotate import vr2_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [COORD_W-1:0] in_a,
  input  wire logic signed [COORD_W-1:0] in_b,
  input  wire trig_t                     in_t,
  input  wire side_t                     in_side,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [COORD_W-1:0]      out_p,
  output logic signed [COORD_W-1:0]      out_q,
  output side_t                          out_side
);

  localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1) <<< (FRAC - 1);
  localparam logic signed [RND_W-1:0] CMAX = RND_W'({1'b0, {(COORD_W - 1){1'b1}}});
  localparam logic signed [RND_W-1:0] CMIN = -CMAX - RND_W'(1);

  logic                      va_r, vb_r, adv_a, adv_b;
  logic signed [PROD_W-1:0]  ac_r, bs_r, as_r, bc_r;
  side_t                     side_a_r, side_b_r;
  logic signed [COORD_W-1:0] p_r, q_r;

  logic signed [SUM_W-1:0]   sp, sq;
  logic signed [RND_W-1:0]   rp, rq;
  logic signed [COORD_W-1:0] p_nxt, q_nxt;
  logic                      ovf_nxt;
  side_t                     side_nxt;

  assign adv_b    = !vb_r || out_ready;
  assign adv_a    = !va_r || adv_b;
  assign in_ready = adv_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (adv_a) begin
        va_r <= in_valid;
      end
      if (adv_b) begin
        vb_r <= va_r;
      end
    end
  end

  // products, one register level
  always_ff @(posedge clk) begin
    if (adv_a && in_valid) begin
      ac_r     <= PROD_W'(in_a) * PROD_W'(in_t.c);
      bs_r     <= PROD_W'(in_b) * PROD_W'(in_t.s);
      as_r     <= PROD_W'(in_a) * PROD_W'(in_t.s);
      bc_r     <= PROD_W'(in_b) * PROD_W'(in_t.c);
      side_a_r <= in_side;
    end
  end

  // sum, round half up, saturate
  always_comb begin
    sp      = SUM_W'(ac_r) - SUM_W'(bs_r) + HALF_LSB;
    sq      = SUM_W'(as_r) + SUM_W'(bc_r) + HALF_LSB;
    rp      = RND_W'(sp >>> FRAC);
    rq      = RND_W'(sq >>> FRAC);
    ovf_nxt = side_a_r.ovf;
    if (rp > CMAX) begin
      p_nxt   = COORD_W'(CMAX);
      ovf_nxt = 1'b1;
    end else if (rp < CMIN) begin
      p_nxt   = COORD_W'(CMIN);
      ovf_nxt = 1'b1;
    end else begin
      p_nxt = COORD_W'(rp);
    end
    if (rq > CMAX) begin
      q_nxt   = COORD_W'(CMAX);
      ovf_nxt = 1'b1;
    end else if (rq < CMIN) begin
      q_nxt   = COORD_W'(CMIN);
      ovf_nxt = 1'b1;
    end else begin
      q_nxt = COORD_W'(rq);
    end
    side_nxt     = side_a_r;
    side_nxt.ovf = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (adv_b && va_r) begin
      p_r      <= p_nxt;
      q_r      <= q_nxt;
      side_b_r <= side_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_p     = p_r;
  assign out_q     = q_r;
  assign out_side  = side_b_r;

endmodule
`default_nettype wire

// ===== sv/vector_rotate_two_axis_3d.sv =====
`timescale 1ns / 1ps
`default_nettype none
// rotates a Q16.16 point about the X axis by pitch_angle, then about the Y axis by
// yaw_angle (Q3.13 radians); sine and cosine come from a 16-step pipelined cordic,
// one lane per angle, followed by two rotation units of two stages each (multiply,
// then sum with round half up and saturation). one point is accepted every cycle while the output is not stalled;
// the pipeline is the cordic stages followed by the four rotation stages.
// overflowed is set when any coordinate of either rotation saturated.
module vector_rotate_two_axis_3d import vr2_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // vec_x, vec_y, vec_z, pitch_angle, yaw_angle
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // rot_x, rot_y, rot_z, overflowed, zero pad
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  vec_t                      in_vec;
  logic signed [ANGLE_W-1:0] in_pitch, in_yaw;

  logic  c_valid, c_ready;
  vec_t  c_vec;
  trig_t c_tp, c_tw;
  side_t side1;

  logic                      r1_valid, r1_ready;
  logic signed [COORD_W-1:0] y1, z1;
  side_t                     r1_side, side2;

  logic signed [COORD_W-1:0] z2, x2;
  side_t                     r2_side;

  assign in_vec.x = in_tdata[COORD_W-1:0];
  assign in_vec.y = in_tdata[2*COORD_W-1:COORD_W];
  assign in_vec.z = in_tdata[3*COORD_W-1:2*COORD_W];
  assign in_pitch = in_tdata[3*COORD_W+ANGLE_W-1:3*COORD_W];
  assign in_yaw   = in_tdata[3*COORD_W+2*ANGLE_W-1:3*COORD_W+ANGLE_W];

  vr2_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_vec    (in_vec),
    .in_pitch  (in_pitch),
    .in_yaw    (in_yaw),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .out_vec   (c_vec),
    .out_tp    (c_tp),
    .out_tw    (c_tw)
  );

  assign side1.ovf  = 1'b0;
  assign side1.keep = c_vec.x;
  assign side1.trig = c_tw;

  // about x: p = y1, q = z1
  vr2_rotate u_rot_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c_valid),
    .in_ready  (c_ready),
    .in_a      (c_vec.y),
    .in_b      (c_vec.z),
    .in_t      (c_tp),
    .in_side   (side1),
    .out_valid (r1_valid),
    .out_ready (r1_ready),
    .out_p     (y1),
    .out_q     (z1),
    .out_side  (r1_side)
  );

  assign side2.ovf  = r1_side.ovf;
  assign side2.keep = y1;
  assign side2.trig = '0;

  // about y: p = z2, q = x2
  vr2_rotate u_rot_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (r1_valid),
    .in_ready  (r1_ready),
    .in_a      (z1),
    .in_b      (r1_side.keep),
    .in_t      (r1_side.trig),
    .in_side   (side2),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_p     (z2),
    .out_q     (x2),
    .out_side  (r2_side)
  );

  assign out_tdata = OUT_TDATA_W'({r2_side.ovf, z2, r2_side.keep, x2});

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import vr2_pkg::*;

  typedef struct {
    logic signed [COORD_W-1:0] rx;
    logic signed [COORD_W-1:0] ry;
    logic signed [COORD_W-1:0] rz;
    logic                      ovf;
  } rotated_t;

  // exact fixed-point predictor of the two-axis rotation
  function automatic void trig_of(input logic signed [ANGLE_W-1:0] ang,
                                  output longint s, output longint c);
    longint z, x, y, nx, atn;
    bit flip;
    z = longint'(ang) <<< ANG_SHIFT;
    x = 64'sh26DD3B6A;
    y = 0;
    flip = 0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426; flip = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426; flip = 1;
    end
    for (int i = 0; i < TRIG_ITER; i++) begin
      atn = longint'(atan_q30(i));
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= atn;
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += atn;
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint mac_round(longint c1, longint t1, longint c2, longint t2);
    logic signed [127:0] acc;
    acc = 128'(c1) * 128'(t1) + 128'(c2) * 128'(t2) + (128'sd1 <<< 29);
    acc = acc >>> 30;
    if (acc > 128'sd2147483647) return 64'sd2147483648;
    if (acc < -128'sd2147483648) return -64'sd2147483649;
    return longint'(acc);
  endfunction

  function automatic longint clamp(longint v, ref bit f);
    if (v > 64'sd2147483647) begin f = 1; return 64'sd2147483647; end
    if (v < -64'sd2147483648) begin f = 1; return -64'sd2147483648; end
    return v;
  endfunction

  function automatic rotated_t rotate_point(logic [IN_TDATA_W-1:0] d);
    longint x, y, z, sp, cp, sw, cw, y1, z1, x2, z2;
    bit f;
    rotated_t r;
    x = longint'($signed(d[31:0]));
    y = longint'($signed(d[63:32]));
    z = longint'($signed(d[95:64]));
    trig_of(d[111:96], sp, cp);
    trig_of(d[127:112], sw, cw);
    f = 0;
    y1 = clamp(mac_round(y, cp, z, -sp), f);
    z1 = clamp(mac_round(y, sp, z, cp), f);
    x2 = clamp(mac_round(x, cw, z1, sw), f);
    z2 = clamp(mac_round(x, -sw, z1, cw), f);
    r.rx = x2[31:0]; r.ry = y1[31:0]; r.rz = z2[31:0]; r.ovf = f;
    return r;
  endfunction

  class rotation_board;
    rotated_t pending[$];
    int errors;
    function void note_input(logic [IN_TDATA_W-1:0] d);
      pending.push_back(rotate_point(d));
    endfunction
    function void check_result(logic [OUT_TDATA_W-1:0] d);
      rotated_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.rx) begin
        $error("rot_x expected %0d actual %0d", e.rx, $signed(d[31:0])); errors++;
      end
      if (d[63:32] !== e.ry) begin
        $error("rot_y expected %0d actual %0d", e.ry, $signed(d[63:32])); errors++;
      end
      if (d[95:64] !== e.rz) begin
        $error("rot_z expected %0d actual %0d", e.rz, $signed(d[95:64])); errors++;
      end
      if (d[96] !== e.ovf) begin
        $error("overflowed expected %0d actual %0d", e.ovf, d[96]); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic [OUT_TDATA_W-1:0] out_tdata;
  rotation_board board;
  int cycles;
  bit long_hold;

  vector_rotate_two_axis_3d i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) board.note_input(in_tdata);
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
  end

  // receiver stall pattern, with one long hold
  initial begin
    int mode;
    out_tready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        out_tready <= 0;
        repeat (80) @(posedge clk);
        long_hold = 0;
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 40)) begin
        case (mode)
          0: out_tready <= 1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= $urandom_range(0, 1);
          default: out_tready <= ($urandom_range(0, 4) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic send_point(logic [IN_TDATA_W-1:0] d);
    in_tvalid <= 1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic pause(int n);
    in_tvalid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'(int'($urandom_range(0, 400000)) - 200000);
      2: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
      3: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'(int'($urandom_range(0, 2000000)) - 1000000) <<< 8;
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 16'(int'($urandom_range(0, 25736)) - 12868);
      2: return 16'(int'($urandom_range(0, 200)) + 12768 * ($urandom_range(0, 1) ? 1 : -1));
      default: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    endcase
  endfunction

  initial begin
    logic [31:0] cx[6];
    logic [15:0] an[8];
    cx = '{32'h0, 32'h00010000, 32'hFFFF0000, 32'h7FFFFFFF,
           32'h80000000, 32'h12345678};
    an = '{16'h0, 16'h7FFF, 16'h8000, 16'h3244, 16'hCDBC,
           16'h3243, 16'h6488, 16'h9B78};
    board = new();
    cycles = 0;
    long_hold = 0;
    rst_n <= 0;
    in_tvalid <= 0;
    in_tdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int i = 0; i < 24; i++)
      send_point({an[(i + 3) % 8], an[i % 8], cx[(i + 2) % 6], cx[(i + 1) % 6], cx[i % 6]});
    pause(1);
    drain();
    @(posedge clk);
    long_hold = 1;
    for (int i = 0; i < 1300; i++) begin
      send_point({rand_angle(), rand_angle(), rand_coord(), rand_coord(), rand_coord()});
      if ($urandom_range(0, 9) == 0) pause($urandom_range(1, 6));
      if (i == 600) begin
        pause(1);
        drain();
        @(posedge clk);
      end
    end
    in_tvalid <= 0;
    drain();
    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
